// ===== rtl/rtc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the relation transitive closure block: opcodes, controller
// states, select codes and the command/status structs. No dependencies.

package rtc_pkg;

  localparam int MAX_STATES_DEF = 32;
  localparam int ACT_W          = 6;
  localparam logic [ACT_W-1:0] ACTIVE_RESET = 6'd32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REFLEX = 2'd1,
    OP_TRANS  = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_FIN,
    S_R_START,
    S_R_RD,
    S_R_WR,
    S_T_START,
    S_T_ROW_RD,
    S_T_LOAD,
    S_T_COL,
    S_T_WB,
    S_T_PASSEND
  } state_t;

  typedef enum logic [2:0] {
    RD_PORT,
    RD_ITEM,
    RD_ROW,
    RD_COL,
    RD_COL_NEXT
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_INSERT,
    WR_DIAG,
    WR_WORK
  } wr_sel_t;

  typedef struct packed {
    logic    latch;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    row_clr;
    logic    row_inc;
    logic    col_clr;
    logic    col_inc;
    logic    load_work;
    logic    or_work;
    logic    clr_changed;
    logic    inc_pass;
    logic    set_refl;
  } cmd_t;

  typedef struct packed {
    logic zero_states;
    logic row_last;
    logic col_last;
    logic changed;
    logic insert_ok;
  } status_t;

endpackage

// ===== rtl/rtc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: relation row memory with valid bits, working row, loop counters,
// pass counter, reflexive mark and result formation. Depends on rtc_pkg.

module rtc_datapath #(
  parameter int MAX_STATES = rtc_pkg::MAX_STATES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rtc_pkg::cmd_t            cmd,
  output rtc_pkg::status_t         status,
  input  logic [1:0]               opcode,
  input  logic [4:0]               row_index,
  input  logic [4:0]               col_index,
  input  logic                     cfg_we,
  input  logic [rtc_pkg::ACT_W-1:0] active_states,
  output logic                     bit_value,
  output logic [7:0]               pass_total,
  output logic                     is_reflexive,
  output logic                     index_error
);

  localparam int RW = MAX_STATES;
  localparam int AW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CW = $clog2(MAX_STATES + 1);
  localparam int NW = (CW > rtc_pkg::ACT_W) ? CW : rtc_pkg::ACT_W;

  logic [rtc_pkg::ACT_W-1:0] act_reg;
  logic [NW-1:0]             n_eff;
  logic [NW-1:0]             row_cnt;
  logic [NW-1:0]             col_cnt;
  logic [NW-1:0]             col_next;
  logic [RW-1:0]             mask;

  rtc_pkg::opcode_t op_q;
  logic [4:0]       row_q;
  logic [4:0]       col_q;

  logic [RW-1:0]       mem [MAX_STATES];
  logic [MAX_STATES-1:0] valid;
  logic [RW-1:0]       rdata_q;
  logic                rvalid_q;
  logic [RW-1:0]       rd_row;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [RW-1:0]       wr_data;

  logic [RW-1:0] work;
  logic [RW-1:0] add_bits;
  logic          changed;
  logic [7:0]    pass_cnt;
  logic          refl_mark;
  logic          err;
  logic [RW-1:0] shifted;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      act_reg <= rtc_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      act_reg <= active_states;
    end
  end

  // Clamp the active size to the array size
  always_comb begin
    if (NW'(act_reg) > NW'(MAX_STATES)) begin
      n_eff = NW'(MAX_STATES);
    end else begin
      n_eff = NW'(act_reg);
    end
  end

  always_comb begin
    for (int i = 0; i < RW; i++) begin
      mask[i] = (NW'(i) < n_eff);
    end
  end

  // Latch the item fields at accept
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q  <= rtc_pkg::opcode_t'(opcode);
      row_q <= row_index;
      col_q <= col_index;
    end
  end

  assign err = (NW'(row_q) >= n_eff) || (NW'(col_q) >= n_eff);

  // Loop counters
  assign col_next = col_cnt + NW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else begin
      if (cmd.row_clr) begin
        row_cnt <= '0;
      end else if (cmd.row_inc) begin
        row_cnt <= row_cnt + NW'(1);
      end
      if (cmd.col_clr) begin
        col_cnt <= '0;
      end else if (cmd.col_inc) begin
        col_cnt <= col_next;
      end
    end
  end

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      rtc_pkg::RD_PORT:     rd_addr = AW'(row_index);
      rtc_pkg::RD_ITEM:     rd_addr = AW'(row_q);
      rtc_pkg::RD_ROW:      rd_addr = row_cnt[AW-1:0];
      rtc_pkg::RD_COL:      rd_addr = col_cnt[AW-1:0];
      rtc_pkg::RD_COL_NEXT: rd_addr = col_next[AW-1:0];
      default:              rd_addr = '0;
    endcase
  end

  // Write address and data select
  always_comb begin
    case (cmd.wr_sel)
      rtc_pkg::WR_INSERT: begin
        wr_addr = AW'(row_q);
        wr_data = rd_row | (RW'(1) << col_q);
      end
      rtc_pkg::WR_DIAG: begin
        wr_addr = row_cnt[AW-1:0];
        wr_data = rd_row | (RW'(1) << row_cnt);
      end
      rtc_pkg::WR_WORK: begin
        wr_addr = row_cnt[AW-1:0];
        wr_data = work;
      end
      default: begin
        wr_addr = '0;
        wr_data = '0;
      end
    endcase
  end

  // Row memory, registered read; a row never written reads as zero
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q  <= mem[rd_addr];
    rvalid_q <= valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rvalid_q ? rdata_q : '0;

  // Working row for the closure pass
  assign add_bits = rd_row & mask & ~work;

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      work <= rd_row;
    end else if (cmd.or_work && work[col_cnt[AW-1:0]]) begin
      work <= work | add_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
    end else if (cmd.clr_changed) begin
      changed <= 1'b0;
    end else if (cmd.or_work && work[col_cnt[AW-1:0]] && (|add_bits)) begin
      changed <= 1'b1;
    end
  end

  // Pass counter, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_cnt <= '0;
    end else if (cmd.inc_pass && (pass_cnt != 8'hFF)) begin
      pass_cnt <= pass_cnt + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refl_mark <= 1'b0;
    end else if (cmd.set_refl) begin
      refl_mark <= 1'b1;
    end
  end

  // Status to the controller
  assign status.zero_states = (n_eff == '0);
  assign status.row_last    = (row_cnt == n_eff - NW'(1));
  assign status.col_last    = (col_cnt == n_eff - NW'(1));
  assign status.changed     = changed;
  assign status.insert_ok   = (op_q == rtc_pkg::OP_INSERT) && !err;

  // Result fields
  assign shifted      = rd_row >> col_q;
  assign bit_value    = !err && (shifted[0] || (op_q == rtc_pkg::OP_INSERT));
  assign pass_total   = pass_cnt;
  assign is_reflexive = refl_mark;
  assign index_error  = err;

endmodule

// ===== rtl/rtc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences insert, query and both closures and
// drives the datapath commands. Depends on rtc_pkg.

module rtc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  rtc_pkg::status_t  status,
  output rtc_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);

  rtc_pkg::state_t state;
  rtc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = rtc_pkg::RD_ITEM;
    cmd.wr_sel = rtc_pkg::WR_WORK;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      rtc_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd.rd_sel = rtc_pkg::RD_PORT;
        if (start) begin
          cmd.latch = 1'b1;
          case (rtc_pkg::opcode_t'(opcode))
            rtc_pkg::OP_REFLEX: state_next = rtc_pkg::S_R_START;
            rtc_pkg::OP_TRANS:  state_next = rtc_pkg::S_T_START;
            default:            state_next = rtc_pkg::S_RESP;
          endcase
        end
      end
      rtc_pkg::S_RESP: begin
        done       = 1'b1;
        cmd.wr_sel = rtc_pkg::WR_INSERT;
        cmd.wr_en  = status.insert_ok;
        state_next = rtc_pkg::S_IDLE;
      end
      rtc_pkg::S_FIN: begin
        cmd.rd_sel = rtc_pkg::RD_ITEM;
        state_next = rtc_pkg::S_RESP;
      end
      rtc_pkg::S_R_START: begin
        cmd.row_clr  = 1'b1;
        cmd.set_refl = 1'b1;
        state_next   = status.zero_states ? rtc_pkg::S_FIN : rtc_pkg::S_R_RD;
      end
      rtc_pkg::S_R_RD: begin
        cmd.rd_sel = rtc_pkg::RD_ROW;
        state_next = rtc_pkg::S_R_WR;
      end
      rtc_pkg::S_R_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rtc_pkg::WR_DIAG;
        if (status.row_last) begin
          state_next = rtc_pkg::S_FIN;
        end else begin
          cmd.row_inc = 1'b1;
          state_next  = rtc_pkg::S_R_RD;
        end
      end
      rtc_pkg::S_T_START: begin
        cmd.row_clr     = 1'b1;
        cmd.clr_changed = 1'b1;
        state_next = status.zero_states ? rtc_pkg::S_T_PASSEND : rtc_pkg::S_T_ROW_RD;
      end
      rtc_pkg::S_T_ROW_RD: begin
        cmd.rd_sel  = rtc_pkg::RD_ROW;
        cmd.col_clr = 1'b1;
        state_next  = rtc_pkg::S_T_LOAD;
      end
      rtc_pkg::S_T_LOAD: begin
        cmd.load_work = 1'b1;
        cmd.rd_sel    = rtc_pkg::RD_COL;
        state_next    = rtc_pkg::S_T_COL;
      end
      rtc_pkg::S_T_COL: begin
        cmd.or_work = 1'b1;
        cmd.rd_sel  = rtc_pkg::RD_COL_NEXT;
        if (status.col_last) begin
          state_next = rtc_pkg::S_T_WB;
        end else begin
          cmd.col_inc = 1'b1;
        end
      end
      rtc_pkg::S_T_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rtc_pkg::WR_WORK;
        if (status.row_last) begin
          state_next = rtc_pkg::S_T_PASSEND;
        end else begin
          cmd.row_inc = 1'b1;
          state_next  = rtc_pkg::S_T_ROW_RD;
        end
      end
      rtc_pkg::S_T_PASSEND: begin
        cmd.inc_pass = 1'b1;
        state_next   = status.changed ? rtc_pkg::S_T_START : rtc_pkg::S_FIN;
      end
      default: begin
        state_next = rtc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/relation_transitive_closure_top.sv =====
`timescale 1ns / 1ps
// Relation transitive closure top: boolean relation matrix with insert, query,
// reflexive and transitive closure. Insert and query: result in the cycle after
// the accept. Reflexive closure sets each active row's diagonal bit; transitive
// closure repeats passes over every row and column through the single
// row-memory read port until a pass adds no bit. Synchronous reset clears the
// matrix, pass count and reflexive mark; the receiver cannot stall.
// Depends on rtc_pkg, rtc_ctrl and rtc_datapath.

module relation_transitive_closure_top #(
  parameter int MAX_STATES = rtc_pkg::MAX_STATES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Command channel: item taken when start is high and busy is low
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                opcode,
  input  logic [4:0]                row_index,
  input  logic [4:0]                col_index,
  // Size register; write only while idle
  input  logic                      cfg_we,
  input  logic [rtc_pkg::ACT_W-1:0] active_states,
  // Result, valid for the single cycle that done is high
  output logic                      done,
  output logic                      bit_value,
  output logic [7:0]                pass_total,
  output logic                      is_reflexive,
  output logic                      index_error
);

  rtc_pkg::cmd_t    cmd;
  rtc_pkg::status_t status;

  // Sequencer: one item at a time, busy from accept until its result cycle
  rtc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Row memory plus the closure working row; one column merged per cycle
  rtc_datapath #(
    .MAX_STATES (MAX_STATES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .opcode        (opcode),
    .row_index     (row_index),
    .col_index     (col_index),
    .cfg_we        (cfg_we),
    .active_states (active_states),
    .bit_value     (bit_value),
    .pass_total    (pass_total),
    .is_reflexive  (is_reflexive),
    .index_error   (index_error)
  );

endmodule
